// ----- rtl/wth_pkg.sv -----
// Shared types, constants and hash/class helpers for the word tokenizer.
`default_nettype none

package wth_pkg;

  localparam int MAX_LINE_LEN = 4096;
  localparam int MAX_LINES    = 65536;

  localparam int BYTE_W = 8;
  localparam int CLS_W  = 2;
  localparam int LINE_W = 16;
  localparam int POS_W  = $clog2(MAX_LINE_LEN);
  localparam int LEN_W  = $clog2(MAX_LINE_LEN + 1);
  localparam int HASH_W = 64;

  localparam logic [HASH_W-1:0] HASH_SEED  = 64'h0000_0000_8422_2325;
  localparam logic [8:0]        PRIME_LOW  = 9'h1B3;
  localparam int                PRIME_SHFT = 40;

  localparam logic [CLS_W-1:0] CLS_SPACE = 2'd0;
  localparam logic [CLS_W-1:0] CLS_WORD  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd2;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_SPACES = 4'd1;

  // Queue of result pairs; depth must stay a power of two (pointers wrap).
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Output tdata: line, start, length, hash from the lowest bit up.
  localparam int TDATA_BITS = LINE_W + POS_W + LEN_W + HASH_W;
  localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [LINE_W-1:0] line;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic [HASH_W-1:0] hash;
  } word_t;

  typedef struct packed {
    logic  two;
    word_t w0;
    word_t w1;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W - BYTE_W){b[BYTE_W-1]}}, b};
    // multiply by 2^40 + 0x1B3
    return (x * {{(HASH_W - 9){1'b0}}, PRIME_LOW}) + (x << PRIME_SHFT);
  endfunction

  function automatic logic [CLS_W-1:0] class_of(input logic [BYTE_W-1:0] b);
    logic [CLS_W-1:0] c;
    if (b == 8'h20 || b == 8'h09) begin
      c = CLS_SPACE;
    end else if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F}) begin
      c = CLS_WORD;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b,
                                                  input logic en);
    logic [BYTE_W-1:0] r;
    r = b;
    if (en && b inside {[8'h41:8'h5A]}) begin
      r = b | 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wth_front.sv -----
// Front end: takes bytes, keeps the open word and pushes finished words as pairs.
`default_nettype none

module wth_front import wth_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BYTE_W-1:0]    text_byte_i,
  input  wire logic                 byte_valid_i,
  input  wire logic                 end_of_line_i,
  input  wire logic                 new_chunk_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  input  wire q_stat_t              q_stat_i,
  output logic                      push_o,
  output pair_t                     pair_o
);

  logic              ign_case_q, ign_sp_q;
  logic              in_word_q, in_word_d;
  logic [CLS_W-1:0]  cls_q, cls_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [LINE_W-1:0] line_q, line_d;

  logic              acc;
  logic [BYTE_W-1:0] b;
  logic [CLS_W-1:0]  cls_b;
  logic [HASH_W-1:0] mixed;
  logic [1:0]        n;
  word_t             w0, w1, rec;

  assign in_ready_o = !q_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign b          = fold_case(text_byte_i, ign_case_q);
  assign cls_b      = class_of(b);

  always_comb begin
    in_word_d = in_word_q;
    cls_d     = cls_q;
    hash_d    = hash_q;
    start_d   = start_q;
    len_d     = len_q;
    pos_d     = pos_q;
    line_d    = line_q;
    n         = 2'd0;
    w0        = '0;
    w1        = '0;
    rec       = '0;
    mixed     = '0;

    // chunk mark: close the open word on its old line, then restart numbering
    if (new_chunk_i) begin
      if (in_word_d && !(ign_sp_q && cls_d == CLS_SPACE)) begin
        rec = '{cls: cls_d, line: line_d, start: start_d, len: len_d, hash: hash_d};
        if (n == 2'd0) w0 = rec; else w1 = rec;
        n = n + 2'd1;
      end
      in_word_d = 1'b0;
      line_d    = '0;
      pos_d     = '0;
    end

    mixed = mix_byte((in_word_d && cls_b == cls_d) ? hash_d : HASH_SEED, b);

    if (byte_valid_i) begin
      if (in_word_d && cls_b == cls_d) begin
        if (len_d < LEN_W'(MAX_LINE_LEN)) len_d = len_d + LEN_W'(1);
        hash_d = mixed;
      end else begin
        if (in_word_d && !(ign_sp_q && cls_d == CLS_SPACE)) begin
          rec = '{cls: cls_d, line: line_d, start: start_d, len: len_d, hash: hash_d};
          if (n == 2'd0) w0 = rec; else w1 = rec;
          n = n + 2'd1;
        end
        in_word_d = 1'b1;
        cls_d     = cls_b;
        hash_d    = mixed;
        start_d   = pos_d;
        len_d     = LEN_W'(1);
      end
      if (pos_d < POS_W'(MAX_LINE_LEN - 1)) pos_d = pos_d + POS_W'(1);
    end

    if (end_of_line_i) begin
      if (in_word_d && !(ign_sp_q && cls_d == CLS_SPACE)) begin
        rec = '{cls: cls_d, line: line_d, start: start_d, len: len_d, hash: hash_d};
        if (n == 2'd0) w0 = rec; else w1 = rec;
        n = n + 2'd1;
      end
      in_word_d = 1'b0;
      pos_d     = '0;
      if (line_d != LINE_W'(MAX_LINES - 1)) line_d = line_d + LINE_W'(1);
    end
  end

  assign push_o = acc && (n != 2'd0);
  assign pair_o = '{two: (n == 2'd2), w0: w0, w1: w1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_case_q <= 1'b0;
      ign_sp_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IGNORE_CASE)   ign_case_q <= cfg_data_i[0];
      if (cfg_index_i == CFG_IGNORE_SPACES) ign_sp_q   <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      cls_q     <= CLS_SPACE;
      hash_q    <= HASH_SEED;
      start_q   <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      line_q    <= '0;
    end else if (acc) begin
      in_word_q <= in_word_d;
      cls_q     <= cls_d;
      hash_q    <= hash_d;
      start_q   <= start_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      line_q    <= line_d;
    end
  end

  // an open word always holds at least one byte
  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word_q |-> (len_q != '0))
    else $error("open word with zero length");

endmodule

`default_nettype wire

// ----- rtl/wth_queue.sv -----
// Short queue of result pairs between the front end and the output stage.
`default_nettype none

module wth_queue import wth_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire pair_t pair_i,
  input  wire logic  pop_i,
  output pair_t      pair_o,
  output q_stat_t    stat_o
);

  pair_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign pair_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- rtl/wth_back.sv -----
// Output stage: unpacks queued pairs into one word beat each.
`default_nettype none

module wth_back import wth_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pair_t         pair_i,
  input  wire q_stat_t       q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output word_t              word_o,
  output logic               last_o
);

  pair_t hold_q;
  logic  hold_valid_q;
  logic  idx_q;
  logic  beat, done;

  assign beat        = hold_valid_q && out_ready_i;
  assign done        = idx_q || !hold_q.two;
  assign pop_o       = !q_stat_i.empty && (!hold_valid_q || (beat && done));
  assign out_valid_o = hold_valid_q;
  assign word_o      = idx_q ? hold_q.w1 : hold_q.w0;
  assign last_o      = done;

  always_ff @(posedge clk_i) begin
    if (pop_o) hold_q <= pair_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      idx_q        <= 1'b0;
    end else if (pop_o) begin
      hold_valid_q <= 1'b1;
      idx_q        <= 1'b0;
    end else if (beat) begin
      // advance to the second word, or drain
      if (!done) begin
        idx_q <= 1'b1;
      end else begin
        hold_valid_q <= 1'b0;
        idx_q        <= 1'b0;
      end
    end
  end

  a_idx_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q |-> (hold_valid_q && hold_q.two))
    else $error("second word selected without a pair");

endmodule

`default_nettype wire

// ----- rtl/word_tokenizer_with_hash.sv -----
// Top level of the word tokenizer with 64-bit word hash.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready      tdata text byte, tuser flags, tlast end of line
//  m_axis   out  m_axis_tvalid/tready      tdata word fields, tuser class, tlast last of item
//  cfg      in   cfg_valid_i/cfg_ready_o   cfg_index_i register, cfg_data_i value (bit 0)
//
// One input byte per cycle; the open word's hash step (one 64x9 multiply and a
// shift-add) runs in the same cycle the byte is taken.
// Each finished word is one output beat; an item that closes two words holds the
// output for two beats, absorbed by a four-entry queue of word pairs.
// Input stalls only when that queue is full; cfg_ready_o is always high.
// Reset clears all word state at once; no clearing pass.
`default_nettype none

module word_tokenizer_with_hash import wth_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // text_byte
  input  wire logic [1:0]           s_axis_tuser,  // byte_valid, new_chunk
  input  wire logic                 s_axis_tlast,  // end_of_line
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [TDATA_W-1:0]        m_axis_tdata,  // line_index, start_pos, word_len, word_hash
  output logic [1:0]                m_axis_tuser,  // word_class
  output logic                      m_axis_tlast,  // last_of_run
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  q_stat_t q_stat;
  pair_t   push_pair, head_pair;
  logic    push, pop;
  word_t   word;

  assign cfg_ready_o = 1'b1;

  wth_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .text_byte_i  (s_axis_tdata),
    .byte_valid_i (s_axis_tuser[0]),
    .end_of_line_i(s_axis_tlast),
    .new_chunk_i  (s_axis_tuser[1]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .pair_o       (push_pair)
  );

  wth_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pair_i(push_pair),
    .pop_i (pop),
    .pair_o(head_pair),
    .stat_o(q_stat)
  );

  wth_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pair_i     (head_pair),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .word_o     (word),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tuser = word.cls;
  assign m_axis_tdata = {{(TDATA_W - TDATA_BITS){1'b0}},
                         word.hash, word.len, word.start, word.line};

endmodule

`default_nettype wire
